// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check, reset disables
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/pbnd_pkg.sv -----
// Package: types and constants for the polygon boundary distance core
`timescale 1ns / 1ps
package pbnd_pkg;
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_HEAD = 2'd1;
  localparam logic [1:0] KIND_HAND = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  vertex_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [30:0] distance;
    logic signed [31:0] nearest_x;
    logic signed [31:0] nearest_z;
    logic        replaced;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RDA, S_RDB, S_DIFF,
    S_M0, S_M1, S_M2, S_M3, S_LEN, S_DOT,
    S_DIV, S_OFFX, S_OFFZ, S_CZ, S_CLMP,
    S_Q0, S_Q1, S_SQ, S_NEXT,
    S_SQRT, S_DONE
  } state_t;
endpackage

// ----- rtl/pbnd_mul.sv -----
// Shared registered 33x33 magnitude multiplier
`timescale 1ns / 1ps
module pbnd_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [65:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// ----- rtl/polygon_boundary_nearest_distance_core.sv -----
// A head/hand item keeps busy high while every edge is processed; the projection
// takes the 32-step divide unless it clamps to an end. A load item does not raise busy.
// One item is taken at a time; done rises in the same cycle that busy falls.
// The edge loop runs through one shared multiplier, a restoring divider
// (one bit per cycle) and a bit-pair square root (32 steps).
// Synchronous active-high reset; stored result clears to zero, vertex_count to 2.
`timescale 1ns / 1ps
module polygon_boundary_nearest_distance_core #(
  parameter int MAX_VERTICES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pbnd_pkg::in_item_t   item_in,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_data,
  output logic                 done,
  output pbnd_pkg::out_item_t  item_out
);
  localparam int AW = $clog2(MAX_VERTICES);

  pbnd_pkg::state_t state, state_next;
  logic [8:0] vertex_count;
  logic [31:0] mem_x [MAX_VERTICES];
  logic [31:0] mem_z [MAX_VERTICES];
  logic [31:0] rd_x, rd_z;
  logic [AW-1:0] rd_addr;

  logic [1:0] kind;
  logic signed [33:0] px, pz;
  logic [12:0] n_eff, idx;
  logic signed [33:0] ax, az, bx, bz, dx, dz, wx, wz, cx, cz;
  logic signed [67:0] acc, len2, dot, sq, best;
  logic signed [33:0] best_cx, best_cz;
  logic [67:0] rem;
  logic [31:0] t;
  logic [5:0] cnt;
  logic [30:0] best_distance;
  logic [31:0] best_x, best_z;
  logic [63:0] sv, sres, sbit;
  logic [32:0] ma, mb;
  logic [65:0] mp;

  pbnd_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  function automatic logic [32:0] mag33(input logic signed [33:0] v);
    logic signed [33:0] m;
    m = v < 0 ? -v : v;
    return m[32:0];
  endfunction

  logic [12:0] n_clamp;
  always_comb begin
    n_clamp = {4'd0, vertex_count};
    if (vertex_count < 9'd2) n_clamp = 13'd2;
    if (n_clamp > 13'(MAX_VERTICES)) n_clamp = 13'(MAX_VERTICES);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pbnd_pkg::S_IDLE:
        if (start && (item_in.kind == pbnd_pkg::KIND_HEAD ||
                      item_in.kind == pbnd_pkg::KIND_HAND))
          state_next = pbnd_pkg::S_RDA;
      pbnd_pkg::S_RDA: state_next = pbnd_pkg::S_RDB;
      pbnd_pkg::S_RDB: state_next = pbnd_pkg::S_DIFF;
      pbnd_pkg::S_DIFF: state_next = pbnd_pkg::S_M0;
      pbnd_pkg::S_M0: state_next = pbnd_pkg::S_M1;
      pbnd_pkg::S_M1: state_next = pbnd_pkg::S_M2;
      pbnd_pkg::S_M2: state_next = pbnd_pkg::S_M3;
      pbnd_pkg::S_M3: state_next = pbnd_pkg::S_LEN;
      pbnd_pkg::S_LEN: state_next = pbnd_pkg::S_DOT;
      pbnd_pkg::S_DOT: state_next = pbnd_pkg::S_CLMP;
      pbnd_pkg::S_CLMP:
        if (len2 == 0 || dot <= 0 || dot >= len2) state_next = pbnd_pkg::S_Q0;
        else state_next = pbnd_pkg::S_DIV;
      pbnd_pkg::S_DIV: if (cnt == 6'd31) state_next = pbnd_pkg::S_OFFX;
      pbnd_pkg::S_OFFX: state_next = pbnd_pkg::S_OFFZ;
      pbnd_pkg::S_OFFZ: state_next = pbnd_pkg::S_CZ;
      pbnd_pkg::S_CZ: state_next = pbnd_pkg::S_Q0;
      pbnd_pkg::S_Q0: state_next = pbnd_pkg::S_Q1;
      pbnd_pkg::S_Q1: state_next = pbnd_pkg::S_SQ;
      pbnd_pkg::S_SQ: state_next = pbnd_pkg::S_NEXT;
      pbnd_pkg::S_NEXT:
        state_next = (idx + 13'd1 == n_eff) ? pbnd_pkg::S_SQRT : pbnd_pkg::S_RDA;
      pbnd_pkg::S_SQRT: if (sbit == 0) state_next = pbnd_pkg::S_DONE;
      pbnd_pkg::S_DONE: state_next = pbnd_pkg::S_IDLE;
      default: state_next = pbnd_pkg::S_IDLE;
    endcase
  end

  // multiplier operand select; product shows up in the next state
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      pbnd_pkg::S_M0: begin ma = mag33(dx); mb = mag33(dx); end
      pbnd_pkg::S_M1: begin ma = mag33(dz); mb = mag33(dz); end
      pbnd_pkg::S_M2: begin ma = mag33(dx); mb = mag33(wx); end
      pbnd_pkg::S_M3: begin ma = mag33(dz); mb = mag33(wz); end
      pbnd_pkg::S_OFFX: begin ma = mag33(dx); mb = {1'b0, t}; end
      pbnd_pkg::S_OFFZ: begin ma = mag33(dz); mb = {1'b0, t}; end
      pbnd_pkg::S_Q0: begin ma = mag33(px - cx); mb = mag33(px - cx); end
      pbnd_pkg::S_Q1: begin ma = mag33(pz - cz); mb = mag33(pz - cz); end
      default: ;
    endcase
  end

  always_comb begin
    busy = (state != pbnd_pkg::S_IDLE);
    rd_addr = (state == pbnd_pkg::S_RDA) ? idx[AW-1:0]
            : ((idx + 13'd1 == n_eff) ? '0 : AW'(idx + 13'd1));
  end

  // vertex memory
  always_ff @(posedge clk) begin
    if (state == pbnd_pkg::S_IDLE && start && item_in.kind == pbnd_pkg::KIND_LOAD &&
        {24'd0, item_in.vertex_index} < 32'(MAX_VERTICES)) begin
      mem_x[AW'(item_in.vertex_index)] <= item_in.coord_x;
      mem_z[AW'(item_in.vertex_index)] <= item_in.coord_z;
    end
    rd_x <= mem_x[rd_addr];
    rd_z <= mem_z[rd_addr];
  end

  logic signed [67:0] pprod;
  logic [63:0] offm;
  always_comb begin
    pprod = {2'b00, mp};
    offm = 64'(({32'd0, mp[63:0]} + 96'h8000_0000) >> 32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbnd_pkg::S_IDLE;
      vertex_count <= 9'd2;
      best_distance <= '0;
      best_x <= '0;
      best_z <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_we) vertex_count <= cfg_data;
      unique case (state)
        pbnd_pkg::S_IDLE: if (start) begin
          kind <= item_in.kind;
          px <= 34'(item_in.coord_x);
          pz <= 34'(item_in.coord_z);
          idx <= '0;
          n_eff <= n_clamp;
        end
        pbnd_pkg::S_RDA: ;
        pbnd_pkg::S_RDB: begin
          ax <= 34'(signed'(rd_x));
          az <= 34'(signed'(rd_z));
        end
        pbnd_pkg::S_DIFF: begin
          bx <= 34'(signed'(rd_x));
          bz <= 34'(signed'(rd_z));
          dx <= 34'(signed'(rd_x)) - ax;
          dz <= 34'(signed'(rd_z)) - az;
          wx <= px - ax;
          wz <= pz - az;
        end
        pbnd_pkg::S_M1: acc <= pprod;
        pbnd_pkg::S_M2: acc <= acc + pprod;
        pbnd_pkg::S_M3: begin
          len2 <= acc;
          acc <= ((dx < 0) != (wx < 0)) ? -pprod : pprod;
        end
        pbnd_pkg::S_LEN: dot <= acc + (((dz < 0) != (wz < 0)) ? -pprod : pprod);
        pbnd_pkg::S_DOT: ;
        pbnd_pkg::S_CLMP: begin
          rem <= dot;
          t <= '0;
          cnt <= '0;
          if (len2 == 0 || dot <= 0) begin
            cx <= ax; cz <= az;
          end else if (dot >= len2) begin
            cx <= bx; cz <= bz;
          end
        end
        pbnd_pkg::S_DIV: begin
          cnt <= cnt + 6'd1;
          if ({rem[66:0], 1'b0} >= len2) begin
            rem <= {rem[66:0], 1'b0} - len2;
            t <= {t[30:0], 1'b1};
          end else begin
            rem <= {rem[66:0], 1'b0};
            t <= {t[30:0], 1'b0};
          end
        end
        pbnd_pkg::S_OFFX: ;
        pbnd_pkg::S_OFFZ: cx <= ax + (dx < 0 ? -34'(offm) : 34'(offm));
        pbnd_pkg::S_CZ: cz <= az + (dz < 0 ? -34'(offm) : 34'(offm));
        pbnd_pkg::S_Q1: acc <= pprod;
        pbnd_pkg::S_SQ: sq <= acc + pprod;
        pbnd_pkg::S_NEXT: begin
          if (idx == 0 || sq < best) begin
            best <= sq; best_cx <= cx; best_cz <= cz;
          end
          idx <= idx + 13'd1;
          sres <= '0;
          sbit <= 64'h4000_0000_0000_0000;
          sv <= (idx == 0 || sq < best) ? sq[63:0] : best[63:0];
        end
        pbnd_pkg::S_SQRT: if (sbit != 0) begin
          if (sv >= sres + sbit) begin
            sv <= sv - (sres + sbit);
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
        end
        pbnd_pkg::S_DONE: begin
          logic [30:0] d;
          d = (best[67:62] != 0 || sres[63:31] != 0) ? 31'h7FFF_FFFF : sres[30:0];
          done <= 1'b1;
          item_out.replaced <= 1'b0;
          if (kind == pbnd_pkg::KIND_HEAD || d < best_distance) begin
            best_distance <= d;
            best_x <= best_cx[31:0];
            best_z <= best_cz[31:0];
            item_out.replaced <= 1'b1;
            item_out.distance <= d;
            item_out.nearest_x <= best_cx[31:0];
            item_out.nearest_z <= best_cz[31:0];
          end else begin
            item_out.distance <= best_distance;
            item_out.nearest_x <= best_x;
            item_out.nearest_z <= best_z;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/pbnd_checker.sv -----
// Port-level checker for the polygon boundary distance core
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pbnd_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input pbnd_pkg::out_item_t item_out
);
  `ASSERT_NEXT(a_done_one, clk, rst, done, !done)
  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_start_no_done, clk, rst, start && !busy, !done)
  `ASSERT_NEXT(a_idle_no_done, clk, rst, !busy && !start, !done)
endmodule

bind polygon_boundary_nearest_distance_core pbnd_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .item_out(item_out)
);
